// ----- rtl/snfa_pkg.sv -----
// Package for the sensor normalize / fault / average block.
// Field widths, register indexes, reset levels and divider handshake types.
// No dependencies.
package snfa_pkg;

    localparam int WINDOW_LEN_DEF = 8;
    localparam int ADC_BITS_DEF   = 12;

    localparam int TEMP_W     = 11;
    localparam int HUM_W      = 10;
    localparam int PCT_W      = 7;
    localparam int AVG_W      = 15;
    localparam int QUO_W      = 15;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int SAME_W     = 4;

    localparam int PCT_STEPS  = 7;
    localparam int AVG_STEPS  = 15;
    localparam int Q_FRAC     = 8;
    localparam int PCT_FULL   = 100;

    localparam int DIV_W_DEF  = ADC_BITS_DEF + PCT_STEPS;

    localparam int STUCK_LIMIT = 8;
    localparam int COUNT_MAX   = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -11'sd100;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 11'sd700;

    localparam int SOIL_DRY_RESET     = 3000;
    localparam int SOIL_WET_RESET     = 1200;
    localparam int LIGHT_DARK_RESET   = 200;
    localparam int LIGHT_BRIGHT_RESET = 3800;
    localparam int RAIN_THR_RESET     = 2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOIL_DRY     = 3'd0,
        REG_SOIL_WET     = 3'd1,
        REG_LIGHT_DARK   = 3'd2,
        REG_LIGHT_BRIGHT = 3'd3,
        REG_RAIN_THR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
    } t_div_sts;

endpackage

// ----- rtl/snfa_div.sv -----
// Shared restoring divider: one compare and subtract per cycle.
// Quotient must fit in the requested number of steps.
// Depends on snfa_pkg.
module snfa_div
    import snfa_pkg::*;
#(
    parameter int DIV_W = DIV_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output t_div_sts         o_sts,
    output logic [QUO_W-1:0] o_quo
);

    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            // align divisor with the top quotient bit
            r_cnt <= i_req.steps;
            r_rem <= i_num;
            r_dsh <= i_den << (i_req.steps - STEP_W'(1));
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_quo      = r_q;

endmodule

// ----- rtl/sensor_normalize_fault_average.sv -----
// Top level: sensor normalization, fault detection and soil moving average.
// Sequencer, calibration registers, soil window memory; uses snfa_div.
// Depends on snfa_pkg and snfa_div.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall       | temperature, humidity, soil, rain, light
//  out     | output    | o_out_valid / i_out_stall     | percents, average, rain, held, fault
//  cfg     | input     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item at a time. Soil and light each settle their percent without division
// when the reading is clipped or the pair is equal, and otherwise go through the
// shared divider; the window sum walks the filled slots through the registered
// memory read port and the average then goes through the divider.
// Synchronous active-low reset restores calibration levels and empties the
// window; no clearing pass is needed since the fill count bounds the sum.
// A finished item waits in the output register while the next one is taken;
// a stalled output holds the sequencer in its output state.
module sensor_normalize_fault_average
    import snfa_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int ADC_BITS   = ADC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [TEMP_W-1:0] i_temperature_tenths,
    input  logic                     i_temperature_ok,
    input  logic [HUM_W-1:0]         i_humidity_tenths,
    input  logic                     i_humidity_ok,
    input  logic [ADC_BITS-1:0]      i_soil_sample,
    input  logic [ADC_BITS-1:0]      i_rain_sample,
    input  logic [ADC_BITS-1:0]      i_light_sample,
    // result items
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PCT_W-1:0]         o_soil_percent,
    output logic [AVG_W-1:0]         o_soil_average_q8,
    output logic [PCT_W-1:0]         o_light_percent,
    output logic                     o_raining,
    output logic signed [TEMP_W-1:0] o_held_temperature,
    output logic [HUM_W-1:0]         o_held_humidity,
    output logic                     o_fault_now,
    output logic                     o_alert_raised,
    output logic                     o_alert_kind,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ADC_BITS-1:0]      i_cfg_data
);

    localparam int AW     = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = $clog2(PCT_FULL * WINDOW_LEN + 1);
    localparam int DIV_W  = (ADC_BITS + PCT_STEPS > SUM_W + Q_FRAC) ?
                            (ADC_BITS + PCT_STEPS) : (SUM_W + Q_FRAC);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SOIL,
        S_SOIL_DIV,
        S_LIGHT,
        S_LIGHT_DIV,
        S_UPD,
        S_SUM,
        S_AVG,
        S_AVG_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    // calibration registers
    logic [ADC_BITS-1:0] r_soil_dry, r_soil_wet, r_light_dark, r_light_bright, r_rain_thr;

    // latched item
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_temp_ok;
    logic [HUM_W-1:0]         r_hum;
    logic                     r_hum_ok;
    logic [ADC_BITS-1:0]      r_soil, r_rain, r_light;

    // per-item results
    logic [PCT_W-1:0] r_soil_pct, r_light_pct;
    logic             r_rain_res, r_fault_res, r_raised_res, r_kind_res;

    // running state
    logic [AW-1:0]            r_wslot;
    logic [CNT_W-1:0]         r_fill;
    logic [PCT_W-1:0]         r_prev_soil;
    logic                     r_prev_known;
    logic [SAME_W-1:0]        r_same_cnt;
    logic                     r_fault_flag;
    logic signed [TEMP_W-1:0] r_last_temp;
    logic [HUM_W-1:0]         r_last_hum;

    // window walk
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [PCT_W-1:0] r_rd;
    logic [SUM_W-1:0] r_sum;
    logic [PCT_W-1:0] mem [WINDOW_LEN];

    // shared divider
    t_div_req         div_req;
    t_div_sts         div_sts;
    logic [DIV_W-1:0] div_num, div_den;
    logic [QUO_W-1:0] div_quo;

    // percent setup, shared between soil and light
    logic                pc_light;
    logic [ADC_BITS-1:0] pc_x, pc_lo, pc_hi, pc_z, pc_f, pc_v, pc_d, pc_dd;
    logic                pc_num_neg, pc_den_neg, pc_zero, pc_full;
    logic [DIV_W-1:0]    pc_num;

    // fault update
    logic              same_eq, oor, stuck, now_fault;
    logic [SAME_W-1:0] n_same_cnt;

    always_comb begin
        pc_light = (r_state == S_LIGHT);
        // soil maps dry to 0 and wet to 100, light maps dark to 0 and bright to 100
        pc_x  = pc_light ? r_light        : r_soil;
        pc_lo = pc_light ? r_light_dark   : r_soil_wet;
        pc_hi = pc_light ? r_light_bright : r_soil_dry;
        pc_z  = pc_light ? r_light_dark   : r_soil_dry;
        pc_f  = pc_light ? r_light_bright : r_soil_wet;
        // clamp; a reversed pair lands on one end or the other
        if (pc_x < pc_lo) begin
            pc_v = pc_lo;
        end else if (pc_x > pc_hi) begin
            pc_v = pc_hi;
        end else begin
            pc_v = pc_x;
        end
        pc_num_neg = (pc_v < pc_z);
        pc_d       = pc_num_neg ? (pc_z - pc_v) : (pc_v - pc_z);
        pc_den_neg = (pc_f < pc_z);
        pc_dd      = pc_den_neg ? (pc_z - pc_f) : (pc_f - pc_z);
        // negative quotient clips to zero, one of 100 or more clips to full
        pc_zero    = (pc_dd == '0) || ((pc_d != '0) && (pc_num_neg != pc_den_neg));
        pc_full    = (pc_d >= pc_dd);
        pc_num     = (DIV_W'(pc_d) << 6) + (DIV_W'(pc_d) << 5) + (DIV_W'(pc_d) << 2);
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(PCT_STEPS);
        div_num       = pc_num;
        div_den       = DIV_W'(pc_dd);
        case (r_state)
            S_SOIL, S_LIGHT: begin
                div_req.start = !pc_zero && !pc_full;
            end
            S_AVG: begin
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(AVG_STEPS);
                div_num       = DIV_W'(r_sum) << Q_FRAC;
                div_den       = DIV_W'(r_fill);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        oor = !r_temp_ok || !r_hum_ok || (r_temp < TEMP_LOW) || (r_temp > TEMP_HIGH);
        same_eq = r_prev_known && (r_prev_soil == r_soil_pct);
        if (!same_eq) begin
            n_same_cnt = '0;
        end else if (r_same_cnt < SAME_W'(COUNT_MAX)) begin
            n_same_cnt = r_same_cnt + SAME_W'(1);
        end else begin
            n_same_cnt = r_same_cnt;
        end
        stuck     = (n_same_cnt >= SAME_W'(STUCK_LIMIT));
        now_fault = oor || stuck;
    end

    snfa_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    // soil window: write during update, walk with registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            mem[r_wslot] <= r_soil_pct;
        end
        r_rd <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_soil_dry     <= ADC_BITS'(SOIL_DRY_RESET);
            r_soil_wet     <= ADC_BITS'(SOIL_WET_RESET);
            r_light_dark   <= ADC_BITS'(LIGHT_DARK_RESET);
            r_light_bright <= ADC_BITS'(LIGHT_BRIGHT_RESET);
            r_rain_thr     <= ADC_BITS'(RAIN_THR_RESET);
            r_wslot        <= '0;
            r_fill         <= '0;
            r_prev_soil    <= '0;
            r_prev_known   <= 1'b0;
            r_same_cnt     <= '0;
            r_fault_flag   <= 1'b0;
            r_last_temp    <= '0;
            r_last_hum     <= '0;
            r_addr         <= '0;
            r_rd_vld       <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_SOIL_DRY:     r_soil_dry     <= i_cfg_data;
                    REG_SOIL_WET:     r_soil_wet     <= i_cfg_data;
                    REG_LIGHT_DARK:   r_light_dark   <= i_cfg_data;
                    REG_LIGHT_BRIGHT: r_light_bright <= i_cfg_data;
                    REG_RAIN_THR:     r_rain_thr     <= i_cfg_data;
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end

            // drop the result once taken; the output state refills it itself
            if (o_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_temp    <= i_temperature_tenths;
                        r_temp_ok <= i_temperature_ok;
                        r_hum     <= i_humidity_tenths;
                        r_hum_ok  <= i_humidity_ok;
                        r_soil    <= i_soil_sample;
                        r_rain    <= i_rain_sample;
                        r_light   <= i_light_sample;
                        r_state   <= S_SOIL;
                    end
                end
                S_SOIL: begin
                    if (pc_zero) begin
                        r_soil_pct <= '0;
                        r_state    <= S_LIGHT;
                    end else if (pc_full) begin
                        r_soil_pct <= PCT_W'(PCT_FULL);
                        r_state    <= S_LIGHT;
                    end else begin
                        r_state    <= S_SOIL_DIV;
                    end
                end
                S_SOIL_DIV: begin
                    if (!div_sts.busy) begin
                        r_soil_pct <= div_quo[PCT_W-1:0];
                        r_state    <= S_LIGHT;
                    end
                end
                S_LIGHT: begin
                    if (pc_zero) begin
                        r_light_pct <= '0;
                        r_state     <= S_UPD;
                    end else if (pc_full) begin
                        r_light_pct <= PCT_W'(PCT_FULL);
                        r_state     <= S_UPD;
                    end else begin
                        r_state     <= S_LIGHT_DIV;
                    end
                end
                S_LIGHT_DIV: begin
                    if (!div_sts.busy) begin
                        r_light_pct <= div_quo[PCT_W-1:0];
                        r_state     <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_rain_res   <= (r_rain > r_rain_thr);
                    r_fault_res  <= now_fault;
                    r_raised_res <= now_fault && !r_fault_flag;
                    r_kind_res   <= now_fault && !r_fault_flag && !oor;
                    r_fault_flag <= now_fault;
                    r_same_cnt   <= n_same_cnt;
                    r_prev_soil  <= r_soil_pct;
                    r_prev_known <= 1'b1;
                    if (r_temp_ok) begin
                        r_last_temp <= r_temp;
                    end
                    if (r_hum_ok) begin
                        r_last_hum <= r_hum;
                    end
                    // advance the ring; the fill count saturates at a full window
                    r_wslot <= (r_wslot == AW'(WINDOW_LEN - 1)) ? '0 : (r_wslot + AW'(1));
                    if (r_fill != CNT_W'(WINDOW_LEN)) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_addr   <= '0;
                    r_rd_vld <= 1'b0;
                    r_sum    <= '0;
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUM_W'(r_rd);
                    end
                    if (r_addr != r_fill) begin
                        r_addr   <= r_addr + CNT_W'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_AVG;
                        end
                    end
                end
                S_AVG: begin
                    r_state <= S_AVG_DIV;
                end
                S_AVG_DIV: begin
                    if (!div_sts.busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!o_out_valid || !i_out_stall) begin
                        o_soil_percent     <= r_soil_pct;
                        o_soil_average_q8  <= div_quo[AVG_W-1:0];
                        o_light_percent    <= r_light_pct;
                        o_raining          <= r_rain_res;
                        o_held_temperature <= r_last_temp;
                        o_held_humidity    <= r_last_hum;
                        o_fault_now        <= r_fault_res;
                        o_alert_raised     <= r_raised_res;
                        o_alert_kind       <= r_kind_res;
                        o_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_sts.busy)
        else $error("divider busy while sequencer idle");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_soil_percent <= PCT_W'(PCT_FULL)) &&
                        (o_light_percent <= PCT_W'(PCT_FULL)))
        else $error("percent result above full scale");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_soil_average_q8 <= AVG_W'(PCT_FULL << Q_FRAC)))
        else $error("soil average above full scale");

    a_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alert_raised) |-> o_fault_now)
        else $error("alert without fault");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG) |-> (r_fill != '0) && (r_fill <= CNT_W'(WINDOW_LEN)))
        else $error("window fill count out of range at average");

endmodule
